// ===== sv/bba_pkg.sv =====
package bba_pkg;

    localparam int MAX_BLOCKS = 4096;

    localparam int CFG_W     = 13;
    localparam int BLK_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd1;

    localparam logic [CFG_W-1:0] TOTAL_RESET    = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_RESET = 13'd1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

// ===== sv/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bitmap_block_allocator.sv =====
// first-fit block allocator over a used/free bitmap held in one RAM
// input channel (i_valid/o_ready): i_action selects allocate or free,
//   i_block_in names the block to free
// output channel (o_valid/i_ready): o_block_out and o_ok, one item per request
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 total blocks, 1 reserved blocks), taken in any cycle
// the bitmap is walked one RAM word per cycle from word 0, and the scan stops
//   at the word that holds the answer; a full allocate scan covers 4096 blocks
//   in 128 words of 32 bits
// an invalid free, or an allocate with an empty range, skips the scan and goes straight to the result state
// one request is in work at a time; o_ready is low while it runs and rises the
//   cycle after the result is loaded into the output register
// after reset a clearing pass writes every bitmap word to zero, one word a
//   cycle (MAX_BLOCKS / MAP_WORD_BITS words, 128 by default), with o_ready low
// a stalled receiver holds the result in the output register; the next item
//   is still accepted and runs, and its result waits until the first is taken
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic [BLK_W-1:0]     i_block_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [BLK_W-1:0]     o_block_out,
    output logic                 o_ok,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WCW   = $clog2(DEPTH + 1);
    localparam int JW    = $clog2(MAP_WORD_BITS);
    localparam int BW    = $clog2(MAX_BLOCKS + 1);
    localparam int XW    = ((BW > CFG_W) ? BW : CFG_W) + 2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_clr;
    logic                     r_action;
    logic [XW-1:0]            r_blk;
    logic [XW-1:0]            r_lo;
    logic [XW-1:0]            r_hi;
    logic [WCW-1:0]           r_rd_word;
    logic [XW-1:0]            r_rd_base;
    logic                     r_ev_vld;
    logic [AW-1:0]            r_ev_word;
    logic [XW-1:0]            r_ev_base;
    logic [BLK_W-1:0]         r_res_blk;
    logic                     r_res_ok;
    logic                     r_out_valid;
    logic [BLK_W-1:0]         r_out_blk;
    logic                     r_out_ok;
    logic [CFG_W-1:0]         r_total;
    logic [CFG_W-1:0]         r_reserved;

    logic [XW-1:0]            cfg_lo;
    logic [XW-1:0]            cfg_hi;
    logic [XW-1:0]            in_blk;
    logic                     free_valid;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic                     ram_re;
    logic [MAP_WORD_BITS-1:0] ram_rdata;
    logic signed [XW-1:0]     d_lo;
    logic signed [XW-1:0]     d_hi;
    logic [JW:0]              lo_c;
    logic [JW:0]              hi_c;
    logic [MAP_WORD_BITS-1:0] range_mask;
    logic [MAP_WORD_BITS-1:0] cand;
    logic                     found;
    logic [JW-1:0]            pick;
    logic [XW-1:0]            next_base;
    logic                     alloc_end;
    logic                     free_here;
    logic                     scan_end;
    logic [XW-1:0]            rel_full;
    logic [JW-1:0]            rel;

    // bounds as the request sees them
    always_comb begin
        cfg_lo = (r_reserved == '0) ? XW'(1) : XW'(r_reserved);
        cfg_hi = (XW'(r_total) > XW'(MAX_BLOCKS)) ? XW'(MAX_BLOCKS) : XW'(r_total);
        in_blk = XW'(i_block_in);
        free_valid = (in_blk >= cfg_lo) && (in_blk < cfg_hi);
    end

    // candidate bits of the word under evaluation
    always_comb begin
        d_lo = $signed(r_lo - r_ev_base);
        d_hi = $signed(r_hi - r_ev_base);
        if (d_lo[XW-1]) begin
            lo_c = '0;
        end else if (d_lo > $signed(XW'(MAP_WORD_BITS))) begin
            lo_c = (JW+1)'(MAP_WORD_BITS);
        end else begin
            lo_c = d_lo[JW:0];
        end
        if (d_hi[XW-1]) begin
            hi_c = '0;
        end else if (d_hi > $signed(XW'(MAP_WORD_BITS))) begin
            hi_c = (JW+1)'(MAP_WORD_BITS);
        end else begin
            hi_c = d_hi[JW:0];
        end
        for (int j = 0; j < MAP_WORD_BITS; j++) begin
            range_mask[j] = ((JW+1)'(j) >= lo_c) && ((JW+1)'(j) < hi_c);
        end
        cand  = ~ram_rdata & range_mask;
        found = |cand;
        pick  = '0;
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                pick = JW'(j);
            end
        end
        next_base = r_ev_base + XW'(MAP_WORD_BITS);
        alloc_end = next_base >= r_hi;
        free_here = r_blk < next_base;
        scan_end  = r_ev_vld && ((r_action == ACT_ALLOC) ? (found || alloc_end) : free_here);
        rel_full  = r_blk - r_ev_base;
        rel       = rel_full[JW-1:0];
    end

    // bitmap port control
    always_comb begin
        ram_re    = (r_state == S_SCAN) && (r_rd_word < WCW'(DEPTH));
        ram_we    = 1'b0;
        ram_waddr = r_ev_word;
        ram_wdata = ram_rdata;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (r_state == S_SCAN && r_ev_vld) begin
            if (r_action == ACT_ALLOC) begin
                ram_we    = found;
                ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << pick);
            end else begin
                ram_we    = free_here;
                ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << rel);
            end
        end
    end

    bba_ram #(
        .WIDTH(MAP_WORD_BITS),
        .DEPTH(DEPTH)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_rd_word[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ev_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= TOTAL_RESET;
            r_reserved  <= RESERVED_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOTAL:    r_total    <= i_cfg_data;
                    REG_RESERVED: r_reserved <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_action  <= i_action;
                        r_blk     <= in_blk;
                        r_lo      <= cfg_lo;
                        r_hi      <= cfg_hi;
                        r_rd_word <= '0;
                        r_rd_base <= '0;
                        r_ev_vld  <= 1'b0;
                        r_res_blk <= '0;
                        r_res_ok  <= 1'b0;
                        if (i_action == ACT_FREE) begin
                            r_state <= free_valid ? S_SCAN : S_DONE;
                        end else begin
                            r_state <= (cfg_hi > cfg_lo) ? S_SCAN : S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_ev_vld  <= ram_re && !scan_end;
                    r_ev_word <= r_rd_word[AW-1:0];
                    r_ev_base <= r_rd_base;
                    r_rd_word <= r_rd_word + WCW'(1);
                    r_rd_base <= r_rd_base + XW'(MAP_WORD_BITS);
                    if (r_ev_vld) begin
                        if (r_action == ACT_ALLOC) begin
                            if (found) begin
                                r_res_blk <= BLK_W'(r_ev_base + XW'(pick));
                                r_res_ok  <= 1'b1;
                                r_state   <= S_DONE;
                            end else if (alloc_end) begin
                                r_state  <= S_DONE;
                            end
                        end else if (free_here) begin
                            r_res_ok <= 1'b1;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_blk   <= r_res_blk;
                        r_out_ok    <= r_res_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_block_out = r_out_blk;
    assign o_ok        = r_out_ok;

`ifndef SYNTHESIS
    a_write_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_SCAN) |=> (r_state == S_DONE))
        else $error("bitmap write did not end the scan");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_ok && r_action == ACT_FREE)
            |-> (r_blk >= r_lo && r_blk < r_hi))
        else $error("free reported ok outside the allowed range");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_res_ok) |-> (r_res_blk == '0))
        else $error("failed request reports a nonzero block");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN || r_state == S_DONE))
        else $error("accepted item did not start work");
`endif

endmodule

// ===== dv/tb_bitmap_block_allocator.sv =====
module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam int MAP_BLOCKS = MAX_BLOCKS;
    localparam int WORD_BITS  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] blk;
    } t_alloc_request;

    typedef struct packed {
        logic [BLK_W-1:0] block;
        logic             ok;
    } t_alloc_reply;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 i_action   = 1'b0;
    logic [BLK_W-1:0]     i_block_in = '0;
    logic                 i_ready    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic [BLK_W-1:0]     o_block_out;
    logic                 o_ok;

    bitmap_block_allocator #(
        .MAP_WORD_BITS (WORD_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_block_in  (i_block_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_block_out (o_block_out),
        .o_ok        (o_ok),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    bit [MAP_BLOCKS-1:0] used_blocks;
    logic [CFG_W-1:0]    total_cfg;
    logic [CFG_W-1:0]    reserved_cfg;

    t_alloc_request request_q[$];
    t_alloc_reply   reply_q[$];

    int n_errors  = 0;
    int n_results = 0;

    // driver bookkeeping
    t_alloc_request next_req;
    int             gap_left   = 0;
    int             burst_left = 0;
    bit             take;

    // receiver bookkeeping
    int rx_cycle     = 0;
    int hold_left    = 0;
    int next_hold_at = 400;

    t_alloc_reply want;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_alloc_reply serve_request(input logic act,
                                                   input logic [BLK_W-1:0] blk);
        t_alloc_reply r;
        int lo;
        int hi;
        int b;
        r.block = '0;
        r.ok    = 1'b0;
        lo = (reserved_cfg == 0) ? 1 : int'(reserved_cfg);
        hi = (total_cfg > MAP_BLOCKS) ? MAP_BLOCKS : int'(total_cfg);
        if (act == ACT_ALLOC) begin
            for (b = lo; b < hi && !r.ok; b++) begin
                if (!used_blocks[b]) begin
                    used_blocks[b] = 1'b1;
                    r.block = b[BLK_W-1:0];
                    r.ok    = 1'b1;
                end
            end
        end else if (int'(blk) >= lo && int'(blk) < hi) begin
            used_blocks[blk] = 1'b0;
            r.ok = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic push_req(input logic act, input logic [BLK_W-1:0] blk);
        t_alloc_request r;
        r.action = act;
        r.blk    = blk;
        request_q.push_back(r);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_TOTAL)
            total_cfg = data;
        else if (idx == REG_RESERVED)
            reserved_cfg = data;
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || i_valid || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_bounds(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] reserved);
        wait_idle();
        write_cfg(REG_TOTAL, total);
        write_cfg(REG_RESERVED, reserved);
    endtask

    // segments lean towards filling, draining or a mix
    task automatic queue_requests(input int count, input int win_lo, input int win_hi);
        t_alloc_request r;
        int k;
        int alloc_pct;
        alloc_pct = 50;
        for (k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0:       alloc_pct = 90;
                    1:       alloc_pct = 25;
                    default: alloc_pct = 55;
                endcase
            end
            r.action = ($urandom_range(99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
            if (r.action == ACT_ALLOC || $urandom_range(9) == 0)
                r.blk = BLK_W'($urandom);
            else
                r.blk = BLK_W'($urandom_range(win_hi, win_lo));
            request_q.push_back(r);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            take = 1'b0;
            if (i_valid && o_ready) begin
                reply_q.push_back(serve_request(i_action, i_block_in));
                if (burst_left > 0 && request_q.size() > 0)
                    take = 1'b1;
                else
                    gap_left = ($urandom_range(2) == 0) ? $urandom_range(40, 1) : 0;
            end else if (!i_valid) begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_q.size() > 0) begin
                    take = 1'b1;
                    burst_left = $urandom_range(24, 1);
                end
            end
            if (take) begin
                next_req = request_q.pop_front();
                i_valid    <= 1'b1;
                i_action   <= next_req.action;
                i_block_in <= next_req.blk;
                burst_left--;
            end else if (i_valid && o_ready) begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (n_results >= next_hold_at) begin
            hold_left = 400;
            next_hold_at += 600;
            i_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 300) % 4)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(1) == 1);
                2:       i_ready <= ($urandom_range(3) == 0);
                default: i_ready <= ((rx_cycle % 9) < 4);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results <= n_results + 1;
            if (reply_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item block_out=%0d ok=%0b",
                                          o_block_out, o_ok));
            end else begin
                want = reply_q.pop_front();
                if (o_block_out !== want.block)
                    report_mismatch($sformatf("block_out %0d, predicted %0d",
                                              o_block_out, want.block));
                if (o_ok !== want.ok)
                    report_mismatch($sformatf("ok %0b, predicted %0b", o_ok, want.ok));
            end
        end
    end

    initial begin
        used_blocks  = '0;
        total_cfg    = TOTAL_RESET;
        reserved_cfg = RESERVED_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(REG_TOTAL, TOTAL_RESET);
        write_cfg(REG_RESERVED, RESERVED_RESET);

        // reset bounds: first fit, reserved free, free of an already free block
        push_req(ACT_ALLOC, 12'hFFF);
        push_req(ACT_ALLOC, 12'h000);
        push_req(ACT_ALLOC, 12'hAAA);
        push_req(ACT_FREE,  12'h000);
        push_req(ACT_FREE,  12'hFFF);
        push_req(ACT_FREE,  12'd2);
        push_req(ACT_ALLOC, 12'h555);
        push_req(ACT_FREE,  12'h555);

        // small device, runs out of blocks
        set_bounds(13'd8, 13'd3);
        repeat (6) push_req(ACT_ALLOC, 12'd0);
        push_req(ACT_FREE, 12'd8);
        push_req(ACT_FREE, 12'd2);
        push_req(ACT_FREE, 12'd3);

        // empty device
        set_bounds(13'd0, 13'd1);
        push_req(ACT_ALLOC, 12'd0);
        push_req(ACT_FREE,  12'd0);

        // total above the maximum, reserved of zero
        set_bounds(13'h1FFF, 13'd0);
        push_req(ACT_ALLOC, 12'd0);
        push_req(ACT_FREE,  12'd1);

        // reserved at the total
        set_bounds(13'd4096, 13'd4096);
        push_req(ACT_ALLOC, 12'd0);
        push_req(ACT_FREE,  12'hFFF);

        // only the top block, writes to unused indexes must not touch bounds
        set_bounds(13'd4096, 13'd4095);
        write_cfg(REG_SPARE_A, 13'd0);
        write_cfg(REG_SPARE_B, 13'd0);
        push_req(ACT_ALLOC, 12'd0);
        push_req(ACT_ALLOC, 12'd0);

        set_bounds(13'd4096, 13'd1);
        queue_requests(260, 0, 200);

        set_bounds(13'd64, 13'd8);
        queue_requests(200, 6, 66);

        set_bounds(13'd4096, 13'd4000);
        queue_requests(220, 3990, 4095);

        set_bounds(13'h1FFF, 13'd0);
        queue_requests(180, 0, 150);

        set_bounds(13'd300, 13'd299);
        queue_requests(100, 290, 310);

        set_bounds(13'd5000, 13'd2048);
        queue_requests(220, 2040, 2300);

        set_bounds(13'd4096, 13'd1);
        queue_requests(120, 0, 4095);

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
